### design/udp_socket_demux_table_defines.svh
// Assertion macros shared by the UDP socket table design.
// Needs signals named clock and reset in the module that uses them.
`ifndef UDP_SOCKET_DEMUX_TABLE_DEFINES_SVH
`define UDP_SOCKET_DEMUX_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UDP_SDT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define UDP_SDT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/udp_sdt_pkg.sv
// Package for the UDP socket table: payload structs, codes, control structs.
// No dependencies.
`timescale 1ns / 1ps

package udp_sdt_pkg;

   localparam int NUM_SOCKETS_DEFAULT = 8;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int CSR_DATA_WIDTH      = 16;

   localparam logic [15:0] EPH_MIN_RESET = 16'd49152;
   localparam logic [15:0] EPH_MAX_RESET = 16'd65535;

   typedef enum logic [1:0] {
      CMD_BIND     = 2'd0,
      CMD_CONNECT  = 2'd1,
      CMD_CLOSE    = 2'd2,
      CMD_CLASSIFY = 2'd3
   } cmd_type;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_MATCH   = 2'd1;
   localparam logic [1:0] STATUS_NOMATCH = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EPH_MIN = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EPH_MAX = 2'd1;

   typedef struct packed {
      logic [1:0]  command;
      logic [2:0]  slot;
      logic [15:0] local_port;
      logic [7:0]  scope_or_iface;
      logic [63:0] local_addr_hi;
      logic [63:0] local_addr_lo;
      logic [15:0] remote_port;
      logic [63:0] remote_addr_hi;
      logic [63:0] remote_addr_lo;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  slot_out;
      logic [15:0] port_out;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] local_port;
      logic [7:0]  scope;
      logic [63:0] local_addr_hi;
      logic [63:0] local_addr_lo;
      logic [15:0] remote_port;
      logic [63:0] remote_addr_hi;
      logic [63:0] remote_addr_lo;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic compare;
      logic update;
      logic emit;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_classify;
      logic out_free;
      logic emit_last;
   } dp_status_type;

endpackage

### design/udp_sdt_ctrl.sv
// Controller for the UDP socket table: sequences capture, compare,
// table update and result emission. Depends on udp_sdt_pkg.
`timescale 1ns / 1ps

module udp_sdt_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  udp_sdt_pkg::dp_status_type dp_status,
   output udp_sdt_pkg::ctrl_cmd_type  ctrl_cmd
);
   import udp_sdt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      ctrl_cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl_cmd.capture = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (dp_status.is_classify) begin
               ctrl_cmd.compare = 1'b1;
               state_in = ST_SCAN;
            end else if (dp_status.out_free) begin
               ctrl_cmd.update = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // one result per free output slot, lowest matching entry first
            if (dp_status.out_free) begin
               ctrl_cmd.emit = 1'b1;
               if (dp_status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/udp_sdt_datapath.sv
// Datapath for the UDP socket table: request register, socket entries,
// parallel match, ephemeral counter, config registers and result register.
// Depends on udp_sdt_pkg.
`timescale 1ns / 1ps

module udp_sdt_datapath #(
   parameter int NUM_SOCKETS = udp_sdt_pkg::NUM_SOCKETS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  udp_sdt_pkg::req_type                    req_data,
   input  logic                                    csr_valid,
   input  logic [udp_sdt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [udp_sdt_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output udp_sdt_pkg::rsp_type                    rsp_data,
   input  udp_sdt_pkg::ctrl_cmd_type               ctrl_cmd,
   output udp_sdt_pkg::dp_status_type              dp_status
);
   import udp_sdt_pkg::*;

   localparam int SLOT_IDX_W = (NUM_SOCKETS > 1) ? $clog2(NUM_SOCKETS) : 1;

   req_type                 req_ff;
   entry_type               entry_ff [NUM_SOCKETS];
   logic [NUM_SOCKETS-1:0]  valid_ff;
   logic [NUM_SOCKETS-1:0]  match_ff;
   logic [NUM_SOCKETS-1:0]  match_in;
   logic [NUM_SOCKETS-1:0]  low_onehot;
   logic [SLOT_IDX_W-1:0]   low_idx;
   logic [SLOT_IDX_W-1:0]   slot_idx;
   logic [15:0]             eph_min_ff;
   logic [15:0]             eph_max_ff;
   logic [15:0]             next_eph_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic                    in_range;
   logic                    use_eph;
   logic [15:0]             bind_port;
   logic                    dst_mcast;
   logic                    load_rsp;

   assign slot_idx  = SLOT_IDX_W'(req_ff.slot);
   assign in_range  = ({29'd0, req_ff.slot} < 32'(NUM_SOCKETS));
   assign use_eph   = (req_ff.local_port == 16'd0);
   assign bind_port = use_eph ? next_eph_ff : req_ff.local_port;
   assign dst_mcast = (req_ff.local_addr_hi[63:56] == 8'hff);

   // Compare the datagram against every entry at once
   always_comb begin
      for (int i = 0; i < NUM_SOCKETS; i++) begin
         match_in[i] = valid_ff[i]
            && (entry_ff[i].local_port == req_ff.local_port)
            && (entry_ff[i].scope == 8'd0 || entry_ff[i].scope == req_ff.scope_or_iface)
            && (dst_mcast
                || (entry_ff[i].local_addr_hi == 64'd0 && entry_ff[i].local_addr_lo == 64'd0)
                || (entry_ff[i].local_addr_hi == req_ff.local_addr_hi
                    && entry_ff[i].local_addr_lo == req_ff.local_addr_lo))
            && (entry_ff[i].remote_port == 16'd0
                || (entry_ff[i].remote_port == req_ff.remote_port
                    && ((entry_ff[i].remote_addr_hi == 64'd0
                         && entry_ff[i].remote_addr_lo == 64'd0)
                        || (entry_ff[i].remote_addr_hi == req_ff.remote_addr_hi
                            && entry_ff[i].remote_addr_lo == req_ff.remote_addr_lo))));
      end
   end

   // Isolate and encode the lowest pending match
   assign low_onehot = match_ff & (~match_ff + 1'b1);

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < NUM_SOCKETS; i++) begin
         if (low_onehot[i]) begin
            low_idx = low_idx | SLOT_IDX_W'(i);
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.last = 1'b1;
      if (ctrl_cmd.update) begin
         rsp_in.status   = STATUS_DONE;
         rsp_in.slot_out = req_ff.slot;
         if (req_ff.command == CMD_BIND && in_range) begin
            rsp_in.port_out = bind_port;
         end
      end else if (match_ff == '0) begin
         rsp_in.status = STATUS_NOMATCH;
      end else begin
         rsp_in.status   = STATUS_MATCH;
         rsp_in.slot_out = 3'(low_idx);
         rsp_in.last     = dp_status.emit_last;
      end
   end

   assign load_rsp = ctrl_cmd.update || ctrl_cmd.emit;

   assign dp_status.is_classify = (req_ff.command == CMD_CLASSIFY);
   assign dp_status.out_free    = !rsp_valid_ff || rsp_ready;
   assign dp_status.emit_last   = ((match_ff & ~low_onehot) == '0);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         req_ff <= req_data;
      end
      if (ctrl_cmd.compare) begin
         match_ff <= match_in;
      end else if (ctrl_cmd.emit) begin
         match_ff <= match_ff & ~low_onehot;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
      // Entries need no clearing: bind rewrites every field in the same update that sets valid
      if (ctrl_cmd.update && in_range) begin
         case (req_ff.command)
            CMD_BIND: begin
               entry_ff[slot_idx].local_port     <= bind_port;
               entry_ff[slot_idx].scope          <= req_ff.scope_or_iface;
               entry_ff[slot_idx].local_addr_hi  <= req_ff.local_addr_hi;
               entry_ff[slot_idx].local_addr_lo  <= req_ff.local_addr_lo;
               entry_ff[slot_idx].remote_port    <= 16'd0;
               entry_ff[slot_idx].remote_addr_hi <= 64'd0;
               entry_ff[slot_idx].remote_addr_lo <= 64'd0;
            end
            CMD_CONNECT: begin
               entry_ff[slot_idx].remote_port    <= req_ff.remote_port;
               entry_ff[slot_idx].remote_addr_hi <= req_ff.remote_addr_hi;
               entry_ff[slot_idx].remote_addr_lo <= req_ff.remote_addr_lo;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         eph_min_ff   <= EPH_MIN_RESET;
         eph_max_ff   <= EPH_MAX_RESET;
         next_eph_ff  <= EPH_MIN_RESET;
      end else begin
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ctrl_cmd.update && in_range) begin
            case (req_ff.command)
               CMD_BIND:  valid_ff[slot_idx] <= 1'b1;
               CMD_CLOSE: valid_ff[slot_idx] <= 1'b0;
               default: begin
               end
            endcase
         end
         // Advance the ephemeral counter, wrap to the range start
         if (ctrl_cmd.update && in_range && req_ff.command == CMD_BIND && use_eph) begin
            if (next_eph_ff < eph_max_ff) begin
               next_eph_ff <= next_eph_ff + 16'd1;
            end else begin
               next_eph_ff <= eph_min_ff;
            end
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_EPH_MIN: eph_min_ff <= csr_data;
               CSR_EPH_MAX: eph_max_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

endmodule

### design/udp_socket_demux_table.sv
// Channel  | Ports                          | Moves
// req      | req_valid/req_ready, req_data  | one command or datagram header
// rsp      | rsp_valid/rsp_ready, rsp_data  | one result, last marks the final one
// csr      | csr_valid/csr_ready, csr_index | ephemeral range register write
//
// Bind, connect and close take the transfer cycle, then a step that updates the
// table and loads the result register once the output is free.
// Classify takes the transfer cycle, a compare of all entries, then one result
// load per match (one load if there is none) in ascending slot order.
// A result held by rsp_ready stalls the controller; the next request is
// taken only after the previous item's last result is loaded.
// Reset clears the valid bits and rsp_valid and loads the counter and the range registers at once.
//
// Top level of the UDP socket table. Uses udp_sdt_pkg, udp_sdt_ctrl,
// udp_sdt_datapath and udp_socket_demux_table_defines.svh.
`timescale 1ns / 1ps
`include "udp_socket_demux_table_defines.svh"

module udp_socket_demux_table #(
   parameter int NUM_SOCKETS = udp_sdt_pkg::NUM_SOCKETS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  udp_sdt_pkg::req_type                    req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output udp_sdt_pkg::rsp_type                    rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [udp_sdt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [udp_sdt_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import udp_sdt_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;
   logic          take_req;
   logic          take_classify;

   assign csr_ready = 1'b1;

   assign take_req      = req_valid && req_ready;
   assign take_classify = take_req && (req_data.command == CMD_CLASSIFY);

   udp_sdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   udp_sdt_datapath #(
      .NUM_SOCKETS (NUM_SOCKETS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .ctrl_cmd  (ctrl_cmd),
      .dp_status (dp_status)
   );

   `UDP_SDT_ASSERT_NOW(a_update_free, ctrl_cmd.update, dp_status.out_free, "update with rsp held")
   `UDP_SDT_ASSERT_NOW(a_emit_free, ctrl_cmd.emit, dp_status.out_free, "emit with rsp held")
   `UDP_SDT_ASSERT_NEXT(a_busy_after_take, take_req, !req_ready, "ready right after a transfer")
   `UDP_SDT_ASSERT_NEXT(a_classify_cmp, take_classify, ctrl_cmd.compare, "no compare")

endmodule
